// ===== sv/lslf_pkg.sv =====
package lslf_pkg;

   localparam int OUT_BITS  = 32;
   localparam int FRAC_BITS = 16;
   localparam int SEL_BITS  = 3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_DEGENERATE = 2'd1;
   localparam logic [1:0] STATUS_SATURATED  = 2'd2;
   localparam logic [1:0] STATUS_DROPPED    = 2'd3;

   // product order: n*sxy, sx*sy, n*sxx, sx*sx, sxx*sy, sx*sxy
   localparam logic [SEL_BITS-1:0] PROD_N_SXY   = 3'd0;
   localparam logic [SEL_BITS-1:0] PROD_SX_SY   = 3'd1;
   localparam logic [SEL_BITS-1:0] PROD_N_SXX   = 3'd2;
   localparam logic [SEL_BITS-1:0] PROD_SX_SX   = 3'd3;
   localparam logic [SEL_BITS-1:0] PROD_SXX_SY  = 3'd4;
   localparam logic [SEL_BITS-1:0] PROD_SX_SXY  = 3'd5;

   localparam logic [SEL_BITS-1:0] DIV_SLOPE     = 3'd0;
   localparam logic [SEL_BITS-1:0] DIV_INTERCEPT = 3'd1;

   typedef struct packed {
      logic                accept;
      logic                mul_start;
      logic                mul_step;
      logic                mul_store;
      logic                div_start;
      logic                div_step;
      logic                div_store;
      logic                finish;
      logic [SEL_BITS-1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic den_bad;
   } status_type;

endpackage

// ===== sv/lslf_ctrl.sv =====
module lslf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_last_point,
   input  lslf_pkg::status_type status,
   output lslf_pkg::cmd_type   cmd,
   output logic                busy
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DRAIN     = 4'd1;
   localparam logic [3:0] ST_MUL_LOAD  = 4'd2;
   localparam logic [3:0] ST_MUL_RUN   = 4'd3;
   localparam logic [3:0] ST_MUL_STORE = 4'd4;
   localparam logic [3:0] ST_DIV_LOAD  = 4'd5;
   localparam logic [3:0] ST_DIV_RUN   = 4'd6;
   localparam logic [3:0] ST_DIV_STORE = 4'd7;
   localparam logic [3:0] ST_FINISH    = 4'd8;

   logic [3:0]                    state_ff, state_in;
   logic [lslf_pkg::SEL_BITS-1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.sel  = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (req_last_point) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            idx_in   = lslf_pkg::PROD_N_SXY;
            state_in = ST_MUL_LOAD;
         end
         ST_MUL_LOAD: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_MUL_RUN;
         end
         ST_MUL_RUN: begin
            if (status.mul_done) begin
               state_in = ST_MUL_STORE;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         ST_MUL_STORE: begin
            cmd.mul_store = 1'b1;
            if (idx_ff == lslf_pkg::PROD_SX_SXY) begin
               idx_in   = lslf_pkg::DIV_SLOPE;
               state_in = status.den_bad ? ST_FINISH : ST_DIV_LOAD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_MUL_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (status.div_done) begin
               state_in = ST_DIV_STORE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_DIV_STORE: begin
            cmd.div_store = 1'b1;
            if (idx_ff == lslf_pkg::DIV_INTERCEPT) begin
               state_in = ST_FINISH;
            end else begin
               idx_in   = lslf_pkg::DIV_INTERCEPT;
               state_in = ST_DIV_LOAD;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== sv/lslf_datapath.sv =====
module lslf_datapath #(
   parameter int MAX_POINTS  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lslf_pkg::cmd_type             cmd,
   input  logic signed [SAMPLE_BITS-1:0] req_point_x,
   input  logic signed [SAMPLE_BITS-1:0] req_point_y,
   output lslf_pkg::status_type          status,
   output logic                          rsp_strobe,
   output logic [lslf_pkg::OUT_BITS-1:0] rsp_slope,
   output logic [lslf_pkg::OUT_BITS-1:0] rsp_intercept,
   output logic [1:0]                    rsp_fit_status
);

   localparam int S    = SAMPLE_BITS;
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int SXW  = S + CW;
   localparam int SPW  = 2 * S + CW;
   localparam int OW   = SPW;
   localparam int PW   = 2 * OW;
   localparam int SH   = lslf_pkg::FRAC_BITS + 1;
   localparam int DW   = PW + SH + 1;
   localparam int CNTW = $clog2(DW + 1);
   localparam int OB   = lslf_pkg::OUT_BITS;

   // accumulate pipeline
   logic                   pipe_valid_ff;
   logic signed [S-1:0]    x_ff, y_ff;
   logic signed [2*S-1:0]  xy_ff, xx_ff, xy_in, xx_in;
   logic [CW-1:0]          count_ff;
   logic signed [SXW-1:0]  sx_ff, sy_ff;
   logic signed [SPW-1:0]  sxy_ff, sxx_ff;
   logic                   ovf_ff, sat_ff;

   // shared step counter
   logic [CNTW-1:0]        cnt_ff;

   // serial multiplier
   logic signed [OW-1:0]   a_op, b_op;
   logic [OW-1:0]          a_mag, b_mag, b_ff;
   logic [PW-1:0]          sh_ff, acc_ff, prod;
   logic                   mneg_ff;
   logic signed [PW-1:0]   term_ff, num_ff, den_ff, inum_ff, diff;

   // serial divider
   logic signed [PW-1:0]   dv;
   logic [PW-1:0]          dmag;
   logic [DW-1:0]          d_ff, v_ff, q_ff;
   logic [DW:0]            rem_ff, r2;
   logic                   dneg_ff, hi_nz, qsat;
   logic [OB-1:0]          qval, slope_ff, icpt_ff;

   logic                   rsp_strobe_ff;
   logic [OB-1:0]          rsp_slope_ff, rsp_icpt_ff;
   logic [1:0]             rsp_status_ff;

   assign xy_in = req_point_x * req_point_y;
   assign xx_in = req_point_x * req_point_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
      end else begin
         pipe_valid_ff <= cmd.accept;
      end
      if (cmd.accept) begin
         x_ff  <= req_point_x;
         y_ff  <= req_point_y;
         xy_ff <= xy_in;
         xx_ff <= xx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         count_ff <= '0;
         sx_ff    <= '0;
         sy_ff    <= '0;
         sxy_ff   <= '0;
         sxx_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (pipe_valid_ff) begin
         if (count_ff < CW'(MAX_POINTS)) begin
            count_ff <= count_ff + 1'b1;
            sx_ff    <= sx_ff + SXW'(x_ff);
            sy_ff    <= sy_ff + SXW'(y_ff);
            sxy_ff   <= sxy_ff + SPW'(xy_ff);
            sxx_ff   <= sxx_ff + SPW'(xx_ff);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      a_op = OW'(sx_ff);
      b_op = OW'(sxy_ff);
      case (cmd.sel)
         lslf_pkg::PROD_N_SXY: begin
            a_op = $signed(OW'(count_ff));
            b_op = OW'(sxy_ff);
         end
         lslf_pkg::PROD_SX_SY: begin
            a_op = OW'(sx_ff);
            b_op = OW'(sy_ff);
         end
         lslf_pkg::PROD_N_SXX: begin
            a_op = $signed(OW'(count_ff));
            b_op = OW'(sxx_ff);
         end
         lslf_pkg::PROD_SX_SX: begin
            a_op = OW'(sx_ff);
            b_op = OW'(sx_ff);
         end
         lslf_pkg::PROD_SXX_SY: begin
            a_op = OW'(sxx_ff);
            b_op = OW'(sy_ff);
         end
         lslf_pkg::PROD_SX_SXY: begin
            a_op = OW'(sx_ff);
            b_op = OW'(sxy_ff);
         end
         default: begin
            a_op = OW'(sx_ff);
            b_op = OW'(sxy_ff);
         end
      endcase
   end

   assign a_mag = a_op[OW-1] ? OW'(-a_op) : OW'(a_op);
   assign b_mag = b_op[OW-1] ? OW'(-b_op) : OW'(b_op);
   assign prod  = mneg_ff ? PW'(-acc_ff) : acc_ff;
   assign diff  = term_ff - $signed(prod);

   always_ff @(posedge clock) begin
      if (cmd.mul_start || cmd.div_start) begin
         cnt_ff <= '0;
      end else if (cmd.mul_step || cmd.div_step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.mul_start) begin
         sh_ff   <= PW'(a_mag);
         b_ff    <= b_mag;
         acc_ff  <= '0;
         mneg_ff <= a_op[OW-1] ^ b_op[OW-1];
      end else if (cmd.mul_step) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + sh_ff;
         end
         sh_ff <= {sh_ff[PW-2:0], 1'b0};
         b_ff  <= {1'b0, b_ff[OW-1:1]};
      end
      if (cmd.mul_store) begin
         if (!cmd.sel[0]) begin
            term_ff <= $signed(prod);
         end else begin
            case (cmd.sel[2:1])
               2'd0:    num_ff  <= diff;
               2'd1:    den_ff  <= diff;
               default: inum_ff <= diff;
            endcase
         end
      end
   end

   assign status.mul_done = (cnt_ff == CNTW'(OW));
   assign status.div_done = (cnt_ff == CNTW'(DW));
   assign status.den_bad  = den_ff[PW-1] || (den_ff == '0);

   assign dv   = (cmd.sel == lslf_pkg::DIV_SLOPE) ? num_ff : inum_ff;
   assign dmag = dv[PW-1] ? PW'(-dv) : PW'(dv);
   assign r2   = {rem_ff[DW-1:0], d_ff[DW-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         d_ff    <= {1'b0, dmag, SH'(0)} + DW'(unsigned'(den_ff));
         v_ff    <= {SH'(0), den_ff, 1'b0};
         rem_ff  <= '0;
         q_ff    <= '0;
         dneg_ff <= dv[PW-1];
      end else if (cmd.div_step) begin
         d_ff <= {d_ff[DW-2:0], 1'b0};
         if (r2 >= {1'b0, v_ff}) begin
            rem_ff <= r2 - {1'b0, v_ff};
            q_ff   <= {q_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= r2;
            q_ff   <= {q_ff[DW-2:0], 1'b0};
         end
      end
   end

   assign hi_nz = |q_ff[DW-1:OB];

   always_comb begin
      if (dneg_ff) begin
         qsat = hi_nz || (q_ff[OB-1:0] > {1'b1, (OB-1)'(0)});
         qval = qsat ? {1'b1, (OB-1)'(0)} : OB'(-q_ff[OB-1:0]);
      end else begin
         qsat = hi_nz || q_ff[OB-1];
         qval = qsat ? {1'b0, {(OB-1){1'b1}}} : q_ff[OB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         sat_ff <= 1'b0;
      end else if (cmd.div_store && qsat) begin
         sat_ff <= 1'b1;
      end
      if (cmd.div_store) begin
         if (cmd.sel == lslf_pkg::DIV_SLOPE) begin
            slope_ff <= qval;
         end else begin
            icpt_ff <= qval;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.finish;
      end
      if (cmd.finish) begin
         if (status.den_bad) begin
            rsp_slope_ff  <= '0;
            rsp_icpt_ff   <= '0;
            rsp_status_ff <= lslf_pkg::STATUS_DEGENERATE;
         end else begin
            rsp_slope_ff <= slope_ff;
            rsp_icpt_ff  <= icpt_ff;
            if (ovf_ff) begin
               rsp_status_ff <= lslf_pkg::STATUS_DROPPED;
            end else if (sat_ff) begin
               rsp_status_ff <= lslf_pkg::STATUS_SATURATED;
            end else begin
               rsp_status_ff <= lslf_pkg::STATUS_OK;
            end
         end
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_slope      = rsp_slope_ff;
   assign rsp_intercept  = rsp_icpt_ff;
   assign rsp_fit_status = rsp_status_ff;

endmodule

// ===== sv/least_squares_line_fit.sv =====
// least-squares line fit over a stream of signed points
// input: a point word (req_point_x, req_point_y, req_last_point) is taken at a
//   clock edge with start high and busy low; one point per cycle between fits
// each point is squared and multiplied in the accept cycle, then added to the
//   count and the four sums in the next cycle; points over MAX_POINTS are
//   dropped and flagged
// on a last point busy rises; six products run one at a time on a shift-add
//   multiplier of OW = 2*SAMPLE_BITS+CW steps (CW = clog2(MAX_POINTS+1)),
//   then two restoring divisions of DW = 2*OW+18 steps; a degenerate set
//   skips the divisions
// result: rsp_slope, rsp_intercept (Q16.16) and rsp_fit_status show for one
//   cycle with rsp_strobe high; the receiver cannot stall, busy is already low
//   in that cycle and the sums are cleared
// reset: synchronous, clears the sums, the count and the controller
module least_squares_line_fit #(
   parameter int MAX_POINTS  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [SAMPLE_BITS-1:0] req_point_x,
   input  logic signed [SAMPLE_BITS-1:0] req_point_y,
   input  logic                          req_last_point,
   output logic                          rsp_strobe,
   output logic signed [31:0]            rsp_slope,
   output logic signed [31:0]            rsp_intercept,
   output logic [1:0]                    rsp_fit_status
);

   lslf_pkg::cmd_type    cmd;
   lslf_pkg::status_type status;

   lslf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_last_point (req_last_point),
      .status         (status),
      .cmd            (cmd),
      .busy           (busy)
   );

   lslf_datapath #(
      .MAX_POINTS  (MAX_POINTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .status         (status),
      .rsp_strobe     (rsp_strobe),
      .rsp_slope      (rsp_slope),
      .rsp_intercept  (rsp_intercept),
      .rsp_fit_status (rsp_fit_status)
   );

endmodule

// ===== sv/lslf_checker.sv =====
module lslf_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_last_point,
   input logic        rsp_strobe,
   input logic [31:0] rsp_slope,
   input logic [31:0] rsp_intercept,
   input logic [1:0]  rsp_fit_status
);

   // each result follows a whole fit, so results never come back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe on two cycles in a row");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_point) |=> busy)
      else $error("no fit started after last point");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while fit still busy");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_fit_status == lslf_pkg::STATUS_DEGENERATE)
         |-> (rsp_slope == '0 && rsp_intercept == '0))
      else $error("degenerate fit with nonzero result");

endmodule

bind least_squares_line_fit lslf_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_last_point (req_last_point),
   .rsp_strobe     (rsp_strobe),
   .rsp_slope      (rsp_slope),
   .rsp_intercept  (rsp_intercept),
   .rsp_fit_status (rsp_fit_status)
);
